FILE: rtl/core/ldsw_pkg.sv
// ----------------------------------------------------------------------------
// ldsw_pkg
// Shared types, codes and widths of the LED dimmer with sleep / wake manager.
// ----------------------------------------------------------------------------
package ldsw_pkg;

    // channel widths
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MOOD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POWER  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAKE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd5;

    // power request values
    localparam logic [VALUE_W-1:0] PWR_OFF = 16'd0;
    localparam logic [VALUE_W-1:0] PWR_ON  = 16'd1;

    // animation modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_SLEEP = 3'd1;
    localparam logic [2:0] MODE_WAKE  = 3'd2;
    localparam logic [2:0] MODE_OFF   = 3'd3;
    localparam logic [2:0] MODE_ON    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FPS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ON_STEP    = 3'd4;

    // reset values
    localparam logic [CFG_W-1:0]  FPS_RST        = 8'd50;
    localparam logic [CFG_W-1:0]  SLOW_STEP_RST  = 8'd1;
    localparam logic [CFG_W-1:0]  FAST_STEP_RST  = 8'd8;
    localparam logic [CHAN_W-1:0] CHAN_RST       = 8'd128;
    localparam logic [CHAN_W-1:0] SCALE_FULL     = 8'd255;

    // status and colour handed from the state update to the rescale stage
    typedef struct packed {
        logic [CHAN_W-1:0]  scale;
        logic [CHAN_W-1:0]  mood_red;
        logic [CHAN_W-1:0]  mood_green;
        logic [CHAN_W-1:0]  mood_blue;
        logic               refresh;
        logic               lit;
        logic               powered_down;
        logic               blank_strip;
        logic [VALUE_W-1:0] wake_left;
        logic [VALUE_W-1:0] sleep_left;
        logic               error;
    } t_s1;

    // one result item
    typedef struct packed {
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
        logic               lit;
        logic               powered_down;
        logic               blank_strip;
        logic               refresh;
        logic [VALUE_W-1:0] wake_left;
        logic [VALUE_W-1:0] sleep_left;
        logic               error;
    } t_res;

endpackage

FILE: rtl/core/ldsw_ctrl.sv
// ----------------------------------------------------------------------------
// ldsw_ctrl
// Configuration registers, fade / timer state and the per-request update.
// ----------------------------------------------------------------------------
module ldsw_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [ldsw_pkg::CMD_W-1:0]     i_cmd,
    input  logic [ldsw_pkg::VALUE_W-1:0]   i_value,
    input  logic [ldsw_pkg::CHAN_W-1:0]    i_mood_red,
    input  logic [ldsw_pkg::CHAN_W-1:0]    i_mood_green,
    input  logic [ldsw_pkg::CHAN_W-1:0]    i_mood_blue,
    input  logic                           i_cfg_we,
    input  logic [ldsw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldsw_pkg::CFG_W-1:0]     i_cfg_data,
    output ldsw_pkg::t_s1                  o_s1
);
    import ldsw_pkg::*;

    logic [CFG_W-1:0]   r_fps, r_sleep_step, r_wake_step, r_off_step, r_on_step;
    logic [CHAN_W-1:0]  r_scale, n_scale;
    logic [2:0]         r_mode, n_mode;
    logic               r_down, n_down;
    logic [VALUE_W-1:0] r_sleep, n_sleep;
    logic [VALUE_W-1:0] r_wake, n_wake;
    logic [CFG_W-1:0]   r_presc, n_presc;
    logic [CHAN_W-1:0]  r_mood_r, r_mood_g, r_mood_b;
    logic [CHAN_W-1:0]  n_mood_r, n_mood_g, n_mood_b;
    logic               n_refresh, n_blank, n_error;
    logic [CFG_W-1:0]   fade_step;
    logic               fade_up;
    t_s1                r_s1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps        <= FPS_RST;
            r_sleep_step <= SLOW_STEP_RST;
            r_wake_step  <= SLOW_STEP_RST;
            r_off_step   <= FAST_STEP_RST;
            r_on_step    <= FAST_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FPS:        r_fps        <= i_cfg_data;
                REG_SLEEP_STEP: r_sleep_step <= i_cfg_data;
                REG_WAKE_STEP:  r_wake_step  <= i_cfg_data;
                REG_OFF_STEP:   r_off_step   <= i_cfg_data;
                REG_ON_STEP:    r_on_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state for one request
    always_comb begin
        n_scale   = r_scale;
        n_mode    = r_mode;
        n_down    = r_down;
        n_sleep   = r_sleep;
        n_wake    = r_wake;
        n_presc   = r_presc;
        n_mood_r  = r_mood_r;
        n_mood_g  = r_mood_g;
        n_mood_b  = r_mood_b;
        n_refresh = 1'b0;
        n_blank   = 1'b0;
        n_error   = 1'b0;
        fade_step = r_on_step;
        fade_up   = 1'b1;
        case (i_cmd)
            CMD_TICK: begin
                // one-second prescaler and timer countdowns
                n_presc = r_presc - 8'd1;
                if (n_presc == '0) begin
                    n_presc = r_fps;
                    if (r_sleep != '0) begin
                        n_sleep = r_sleep - 16'd1;
                        if (n_sleep == '0) begin
                            n_mode = MODE_SLEEP;
                        end
                    end
                    if (r_wake != '0) begin
                        n_wake = r_wake - 16'd1;
                        if (n_wake == '0) begin
                            n_down = 1'b0;
                            n_mode = MODE_WAKE;
                        end
                    end
                end
                // saturating fade ramp
                case (n_mode)
                    MODE_SLEEP: begin
                        fade_step = r_sleep_step;
                        fade_up   = 1'b0;
                    end
                    MODE_WAKE: begin
                        fade_step = r_wake_step;
                        fade_up   = 1'b1;
                    end
                    MODE_OFF: begin
                        fade_step = r_off_step;
                        fade_up   = 1'b0;
                    end
                    default: begin
                        fade_step = r_on_step;
                        fade_up   = 1'b1;
                    end
                endcase
                if (n_mode != MODE_IDLE && n_mode <= MODE_ON) begin
                    if (fade_up) begin
                        n_scale = (r_scale < (SCALE_FULL - fade_step)) ?
                                  r_scale + fade_step : SCALE_FULL;
                    end else begin
                        n_scale = (r_scale > fade_step) ? r_scale - fade_step : '0;
                    end
                    n_refresh = 1'b1;
                    if (n_scale == '0) begin
                        n_mode  = MODE_IDLE;
                        n_down  = 1'b1;
                        n_blank = 1'b1;
                    end else if (n_scale == SCALE_FULL) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            CMD_MOOD: begin
                n_mood_r  = i_mood_red;
                n_mood_g  = i_mood_green;
                n_mood_b  = i_mood_blue;
                n_refresh = 1'b1;
            end
            CMD_POWER: begin
                if (i_value == PWR_OFF) begin
                    n_mode = MODE_OFF;
                    if (r_wake == '0 || r_sleep <= r_wake) begin
                        n_sleep = '0;
                    end
                end else if (i_value == PWR_ON) begin
                    n_down = 1'b0;
                    n_mode = MODE_ON;
                    if (r_sleep == '0 || r_wake <= r_sleep) begin
                        n_wake = '0;
                    end
                end else begin
                    n_error = 1'b1;
                end
            end
            CMD_WAKE: begin
                n_wake = i_value;
                if (i_value != '0 && !r_down && (r_sleep == '0 || i_value < r_sleep)) begin
                    n_mode = MODE_OFF;
                end
            end
            CMD_SLEEP: begin
                n_sleep = i_value;
                if (i_value != '0 && (r_wake == '0 || i_value < r_wake)) begin
                    n_down = 1'b0;
                    n_mode = MODE_ON;
                end
            end
            default: ;
        endcase
    end

    // persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= '0;
            r_mode   <= MODE_ON;
            r_down   <= 1'b0;
            r_sleep  <= '0;
            r_wake   <= '0;
            r_presc  <= FPS_RST;
            r_mood_r <= CHAN_RST;
            r_mood_g <= CHAN_RST;
            r_mood_b <= CHAN_RST;
        end else if (i_load) begin
            r_scale  <= n_scale;
            r_mode   <= n_mode;
            r_down   <= n_down;
            r_sleep  <= n_sleep;
            r_wake   <= n_wake;
            r_presc  <= n_presc;
            r_mood_r <= n_mood_r;
            r_mood_g <= n_mood_g;
            r_mood_b <= n_mood_b;
        end
    end

    // request snapshot for the rescale stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1.scale        <= n_scale;
            r_s1.mood_red     <= n_mood_r;
            r_s1.mood_green   <= n_mood_g;
            r_s1.mood_blue    <= n_mood_b;
            r_s1.refresh      <= n_refresh;
            r_s1.lit          <= !n_down && n_mode != MODE_SLEEP && n_mode != MODE_OFF;
            r_s1.powered_down <= n_down;
            r_s1.blank_strip  <= n_blank;
            r_s1.wake_left    <= n_wake;
            r_s1.sleep_left   <= n_sleep;
            r_s1.error        <= n_error;
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: rtl/core/ldsw_scale.sv
// ----------------------------------------------------------------------------
// ldsw_scale
// Colour rescale by the fade scaler and the result register.
// ----------------------------------------------------------------------------
module ldsw_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  ldsw_pkg::t_s1 i_s1,
    output ldsw_pkg::t_res o_res
);
    import ldsw_pkg::*;

    logic [CHAN_W-1:0]   r_eff_r, r_eff_g, r_eff_b;
    logic [CHAN_W-1:0]   n_eff_r, n_eff_g, n_eff_b;
    logic [2*CHAN_W-1:0] prod_r, prod_g, prod_b;
    t_res                r_res;

    // (m*s+128)>>8, a full scaler passes the mood colour through
    assign prod_r = i_s1.mood_red   * i_s1.scale + 16'd128;
    assign prod_g = i_s1.mood_green * i_s1.scale + 16'd128;
    assign prod_b = i_s1.mood_blue  * i_s1.scale + 16'd128;

    always_comb begin
        n_eff_r = r_eff_r;
        n_eff_g = r_eff_g;
        n_eff_b = r_eff_b;
        if (i_s1.refresh) begin
            if (i_s1.scale == SCALE_FULL) begin
                n_eff_r = i_s1.mood_red;
                n_eff_g = i_s1.mood_green;
                n_eff_b = i_s1.mood_blue;
            end else begin
                n_eff_r = prod_r[2*CHAN_W-1:CHAN_W];
                n_eff_g = prod_g[2*CHAN_W-1:CHAN_W];
                n_eff_b = prod_b[2*CHAN_W-1:CHAN_W];
            end
        end
    end

    // effective colour kept between refreshes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_r <= CHAN_RST;
            r_eff_g <= CHAN_RST;
            r_eff_b <= CHAN_RST;
        end else if (i_load) begin
            r_eff_r <= n_eff_r;
            r_eff_g <= n_eff_g;
            r_eff_b <= n_eff_b;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.out_red      <= n_eff_r;
            r_res.out_green    <= n_eff_g;
            r_res.out_blue     <= n_eff_b;
            r_res.lit          <= i_s1.lit;
            r_res.powered_down <= i_s1.powered_down;
            r_res.blank_strip  <= i_s1.blank_strip;
            r_res.refresh      <= i_s1.refresh;
            r_res.wake_left    <= i_s1.wake_left;
            r_res.sleep_left   <= i_s1.sleep_left;
            r_res.error        <= i_s1.error;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/core/led_dimmer_sleep_wake_manager_unit.sv
// ----------------------------------------------------------------------------
// led_dimmer_sleep_wake_manager_unit
// LED strip brightness manager: mood colour, fade scaler, sleep / wake timers.
// ----------------------------------------------------------------------------
// Each accepted request produces exactly one result. A request is taken in
// every cycle while results flow: the first stage updates the fade, mode and
// timer state, the second rescales the colour with three 8x8 multipliers into
// the result register. With the output stalled the block still takes one more
// request into its first stage. Configuration writes are taken in every cycle
// and should only be issued while idle.
module led_dimmer_sleep_wake_manager_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value[15:0], mood_red[23:16], mood_green[31:24], mood_blue[39:32]
    input  logic [ldsw_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd[2:0]
    input  logic [ldsw_pkg::CMD_W-1:0]      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], lit[24],
    // powered_down[25], blank_strip[26], refresh[27], wake_left[43:28],
    // sleep_left[59:44], error[60], zero[63:61]
    output logic [ldsw_pkg::M_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ldsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ldsw_pkg::CFG_W-1:0]      i_cfg_data
);
    import ldsw_pkg::*;

    logic r_s1_valid, r_out_valid;
    logic out_load, s1_load;
    t_s1  s1;
    t_res res;

    // pipeline advance
    assign out_load = r_s1_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_s1_valid || out_load;
    assign s1_load  = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_s1_valid <= s_tvalid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    ldsw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (s1_load),
        .i_cmd        (s_tuser),
        .i_value      (s_tdata[15:0]),
        .i_mood_red   (s_tdata[23:16]),
        .i_mood_green (s_tdata[31:24]),
        .i_mood_blue  (s_tdata[39:32]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_s1         (s1)
    );

    ldsw_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_s1    (s1),
        .o_res   (res)
    );

    // result packing
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, res.error, res.sleep_left, res.wake_left,
                       res.refresh, res.blank_strip, res.powered_down, res.lit,
                       res.out_blue, res.out_green, res.out_red};

endmodule

FILE: rtl/core/ldsw_chk.sv
// ----------------------------------------------------------------------------
// ldsw_chk
// Port-level checks of the LED dimmer manager, bound to the top level.
// ----------------------------------------------------------------------------
module ldsw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // the pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result offered straight after reset");

    // requests are refused only while a result waits on the output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused without output back-pressure");

    // a blanking pulse comes with power-down and a recomputed colour
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[26] |-> m_tdata[25] && m_tdata[27] && !m_tdata[24])
        else $error("blank pulse without power-down");

endmodule

bind led_dimmer_sleep_wake_manager_unit ldsw_chk u_ldsw_chk (.*);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED dimmer with sleep / wake manager. Requests
// go in as bursts with random gaps, results drain under a wandering stall
// pattern, and every result is compared field by field with an in-bench model
// of the fade scaler, animation mode, power-down flag and second countdowns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldsw_pkg::*;

    // command codes the block treats as status
    localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    led_dimmer_sleep_wake_manager_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // model registers
    logic [7:0]  fps_cfg, sleep_step_cfg, wake_step_cfg, off_step_cfg, on_step_cfg;
    // model state
    logic [7:0]  scale_m;
    logic [2:0]  mode_m;
    logic        down_m;
    logic [15:0] sleep_m, wake_m;
    logic [7:0]  prescale_m;
    logic [7:0]  mood_m [3];
    logic [7:0]  eff_m [3];

    t_res status_due [$];
    int   fault_count = 0;
    int   burst_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;

    function automatic void dimmer_reset();
        fps_cfg        = FPS_RST;
        sleep_step_cfg = SLOW_STEP_RST;
        wake_step_cfg  = SLOW_STEP_RST;
        off_step_cfg   = FAST_STEP_RST;
        on_step_cfg    = FAST_STEP_RST;
        scale_m        = 8'd0;
        mode_m         = MODE_ON;
        down_m         = 1'b0;
        sleep_m        = 16'd0;
        wake_m         = 16'd0;
        prescale_m     = FPS_RST;
        for (int c = 0; c < 3; c++) begin
            mood_m[c] = CHAN_RST;
            eff_m[c]  = CHAN_RST;
        end
    endfunction

    function automatic void dimmer_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_W-1:0] data);
        case (idx)
            REG_FPS:        fps_cfg        = data;
            REG_SLEEP_STEP: sleep_step_cfg = data;
            REG_WAKE_STEP:  wake_step_cfg  = data;
            REG_OFF_STEP:   off_step_cfg   = data;
            REG_ON_STEP:    on_step_cfg    = data;
            default: ;
        endcase
    endfunction

    // saturating ramps of the scaler
    function automatic logic [7:0] ramp_down(input logic [7:0] s, input logic [7:0] step);
        return (s > step) ? 8'(s - step) : 8'd0;
    endfunction

    function automatic logic [7:0] ramp_up(input logic [7:0] s, input logic [7:0] step);
        return (s < 8'(SCALE_FULL - step)) ? 8'(s + step) : SCALE_FULL;
    endfunction

    // effective colour, full scale passes the mood colour through
    function automatic void rescale_colour();
        logic [15:0] prod;
        for (int c = 0; c < 3; c++) begin
            prod     = mood_m[c] * scale_m + 16'd128;
            eff_m[c] = (scale_m == SCALE_FULL) ? mood_m[c] : prod[15:8];
        end
    endfunction

    // one request through the model, returns the status it must produce
    function automatic t_res dimmer_step(input logic [CMD_W-1:0] cmd,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [7:0] r, g, b);
        t_res st;
        logic blank, refresh, err;
        blank   = 1'b0;
        refresh = 1'b0;
        err     = 1'b0;
        case (cmd)
            CMD_TICK: begin
                // one-second prescaler and countdowns, sleep before wake
                prescale_m = prescale_m - 8'd1;
                if (prescale_m == 8'd0) begin
                    prescale_m = fps_cfg;
                    if (sleep_m != 16'd0) begin
                        sleep_m = sleep_m - 16'd1;
                        if (sleep_m == 16'd0)
                            mode_m = MODE_SLEEP;
                    end
                    if (wake_m != 16'd0) begin
                        wake_m = wake_m - 16'd1;
                        if (wake_m == 16'd0) begin
                            down_m = 1'b0;
                            mode_m = MODE_WAKE;
                        end
                    end
                end
                // fade step in any active mode
                if (mode_m != MODE_IDLE) begin
                    case (mode_m)
                        MODE_SLEEP: scale_m = ramp_down(scale_m, sleep_step_cfg);
                        MODE_WAKE:  scale_m = ramp_up(scale_m, wake_step_cfg);
                        MODE_OFF:   scale_m = ramp_down(scale_m, off_step_cfg);
                        default:    scale_m = ramp_up(scale_m, on_step_cfg);
                    endcase
                    rescale_colour();
                    refresh = 1'b1;
                    if (scale_m == 8'd0) begin
                        mode_m = MODE_IDLE;
                        down_m = 1'b1;
                        blank  = 1'b1;
                    end else if (scale_m == SCALE_FULL) begin
                        mode_m = MODE_IDLE;
                    end
                end
            end
            CMD_MOOD: begin
                mood_m[0] = r;
                mood_m[1] = g;
                mood_m[2] = b;
                rescale_colour();
                refresh = 1'b1;
            end
            CMD_POWER: begin
                if (value == PWR_OFF) begin
                    mode_m = MODE_OFF;
                    if (wake_m == 16'd0 || sleep_m <= wake_m)
                        sleep_m = 16'd0;
                end else if (value == PWR_ON) begin
                    down_m = 1'b0;
                    mode_m = MODE_ON;
                    if (sleep_m == 16'd0 || wake_m <= sleep_m)
                        wake_m = 16'd0;
                end else begin
                    err = 1'b1;
                end
            end
            CMD_WAKE: begin
                wake_m = value;
                if (value != 16'd0 && !down_m && (sleep_m == 16'd0 || value < sleep_m))
                    mode_m = MODE_OFF;
            end
            CMD_SLEEP: begin
                sleep_m = value;
                if (value != 16'd0 && (wake_m == 16'd0 || value < wake_m)) begin
                    down_m = 1'b0;
                    mode_m = MODE_ON;
                end
            end
            default: ;
        endcase
        st.out_red      = eff_m[0];
        st.out_green    = eff_m[1];
        st.out_blue     = eff_m[2];
        st.lit          = !down_m && mode_m != MODE_SLEEP && mode_m != MODE_OFF;
        st.powered_down = down_m;
        st.blank_strip  = blank;
        st.refresh      = refresh;
        st.wake_left    = wake_m;
        st.sleep_left   = sleep_m;
        st.error        = err;
        return st;
    endfunction

    task automatic flag_fault(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_fault($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // result checker, oldest outstanding status first
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                flag_fault($sformatf("result 0x%0h with no request outstanding", m_tdata));
            end else begin
                want = status_due.pop_front();
                check_field("out_red",      16'(m_tdata[7:0]),   16'(want.out_red));
                check_field("out_green",    16'(m_tdata[15:8]),  16'(want.out_green));
                check_field("out_blue",     16'(m_tdata[23:16]), 16'(want.out_blue));
                check_field("lit",          16'(m_tdata[24]),    16'(want.lit));
                check_field("powered_down", 16'(m_tdata[25]),    16'(want.powered_down));
                check_field("blank_strip",  16'(m_tdata[26]),    16'(want.blank_strip));
                check_field("refresh",      16'(m_tdata[27]),    16'(want.refresh));
                check_field("wake_left",    m_tdata[43:28],      want.wake_left);
                check_field("sleep_left",   m_tdata[59:44],      want.sleep_left);
                check_field("error",        16'(m_tdata[60]),    16'(want.error));
            end
        end
    end

    // result side back-pressure, the pattern is picked anew at random
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // one request, sent in bursts with random gaps between them
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, g, r, value};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        status_due.push_back(dimmer_step(cmd, value, r, g, b));
    endtask

    // hold requests until every outstanding status has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dimmer_write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] fps, input logic [7:0] sleep_step,
                             input logic [7:0] wake_step, input logic [7:0] off_step,
                             input logic [7:0] on_step);
        wait_drained();
        write_reg(REG_FPS, fps);
        write_reg(REG_SLEEP_STEP, sleep_step);
        write_reg(REG_WAKE_STEP, wake_step);
        write_reg(REG_OFF_STEP, off_step);
        write_reg(REG_ON_STEP, on_step);
    endtask

    // mostly short timers so they expire, now and then cancel or full range
    function automatic logic [15:0] pick_seconds();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        else if (r < 16)
            return 16'($urandom_range(1, 8));
        else
            return 16'($urandom);
    endfunction

    task automatic send_random_request();
        int              pick;
        logic [15:0]     v;
        logic [CMD_W-1:0] c;
        pick = $urandom_range(0, 99);
        v    = 16'($urandom);
        if (pick < 52) begin
            c = CMD_TICK;
        end else if (pick < 60) begin
            c = CMD_MOOD;
        end else if (pick < 70) begin
            c = CMD_POWER;
            if ($urandom_range(0, 7) != 0)
                v = 16'($urandom_range(0, 1));
        end else if (pick < 78) begin
            c = CMD_WAKE;
            v = pick_seconds();
        end else if (pick < 86) begin
            c = CMD_SLEEP;
            v = pick_seconds();
        end else if (pick < 90) begin
            // sleep and wake armed for the same second
            v = 16'($urandom_range(1, 4));
            send_request(CMD_SLEEP, v, 8'($urandom), 8'($urandom), 8'($urandom));
            c = CMD_WAKE;
        end else if (pick < 96) begin
            c = CMD_STATUS;
        end else begin
            c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
        end
        send_request(c, v, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // power-on fade out of reset and mood colour extremes
    task automatic test_power_on_fade();
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_MOOD, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_MOOD, 16'd0, 8'd255, 8'd255, 8'd255);
    endtask

    // status-like codes, bad power requests, power off and on
    task automatic test_commands();
        send_request(CMD_STATUS, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        send_request(CMD_SPARE_LO, 16'h5A5A, 8'd1, 8'd2, 8'd3);
        send_request(CMD_SPARE_HI, 16'hA5A5, 8'd4, 8'd5, 8'd6);
        send_request(CMD_POWER, 16'd2, 8'd0, 8'd0, 8'd0);
        send_request(CMD_POWER, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_POWER, PWR_OFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_POWER, PWR_ON, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // timer extremes, cancel by zero, both timers due together
    task automatic test_timers();
        configure(8'd1, 8'd64, 8'd64, 8'd64, 8'd64);
        send_request(CMD_WAKE, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_SLEEP, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_WAKE, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_SLEEP, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_SLEEP, 16'd2, 8'd0, 8'd0, 8'd0);
        send_request(CMD_WAKE, 16'd2, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // zero fade steps and a zero prescaler reload
    task automatic test_zero_settings();
        configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_POWER, PWR_OFF, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
        send_request(CMD_POWER, PWR_ON, 8'd0, 8'd0, 8'd0);
        send_request(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // writes to indexes with no register must change nothing
    task automatic test_unused_regs();
        wait_drained();
        write_reg(REG_SPARE_LO, 8'($urandom));
        write_reg(REG_SPARE_MID, 8'($urandom));
        write_reg(REG_SPARE_HI, 8'($urandom));
    endtask

    // random traffic over several register settings
    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(8'd1, 8'd255, 8'd255, 8'd255, 8'd255);
                1: configure(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
                2: configure(8'd2, 8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)),
                             8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)));
                3: configure(8'd255, 8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)),
                             8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)));
                4: configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                default: configure(8'($urandom_range(1, 4)), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom));
            endcase
            for (int n = 0; n < 232; n++) begin
                if (ph == 2 && n == 116)
                    wait_drained();
                send_random_request();
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_TICK;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_FPS;
        i_cfg_data  <= '0;
        dimmer_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_fade();
        test_commands();
        test_timers();
        test_zero_settings();
        test_unused_regs();
        test_random_phases();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && status_due.size() == 0)
            $display("PASS led_dimmer_sleep_wake_manager_unit");
        else
            $display("FAIL led_dimmer_sleep_wake_manager_unit");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL led_dimmer_sleep_wake_manager_unit");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ldsw_pkg.sv
rtl/core/ldsw_ctrl.sv
rtl/core/ldsw_scale.sv
rtl/core/led_dimmer_sleep_wake_manager_unit.sv
rtl/core/ldsw_chk.sv
sim/tb_top.sv
